// ----- rtl/ham_pixel_decoder_top_assert.svh -----
// Assertion macros for the hold-and-modify decoder.
`ifndef HAM_PIXEL_DECODER_TOP_ASSERT_SVH
`define HAM_PIXEL_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define HPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define HPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hpd_pkg.sv -----
package hpd_pkg;

    localparam int PAL_ENTRIES = 64;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int PAL_IDX_W   = 6;
    localparam int CODE_W      = 8;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 3 * CHAN_W;

    localparam logic [PAL_IDX_W:0] PAL_LIM = (PAL_IDX_W + 1)'(PAL_ENTRIES);

    localparam logic MODE_HAM6 = 1'b0;
    localparam logic MODE_HAM8 = 1'b1;

    localparam logic REQ_PIXEL   = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    // HAM6 control nibble
    localparam logic [3:0] CTL6_LOAD  = 4'h0;
    localparam logic [3:0] CTL6_BLUE  = 4'h1;
    localparam logic [3:0] CTL6_RED   = 4'h2;
    localparam logic [3:0] CTL6_GREEN = 4'h3;

    // HAM8 control bits
    localparam logic [1:0] CTL8_LOAD  = 2'd0;
    localparam logic [1:0] CTL8_BLUE  = 2'd1;
    localparam logic [1:0] CTL8_RED   = 2'd2;
    localparam logic [1:0] CTL8_GREEN = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_BLUE  = 3'd2,
        OP_RED   = 3'd3,
        OP_GREEN = 3'd4
    } t_ham_op;

    typedef struct packed {
        t_ham_op                op;
        logic [CHAN_W-1:0]      inten;
        logic [PAL_IDX_W-1:0]   idx;
    } t_hpd_dec;

endpackage

// ----- rtl/hpd_code_dec.sv -----
module hpd_code_dec (
    input  logic                          i_ham_mode,
    input  logic [hpd_pkg::CODE_W-1:0]    i_code,
    output hpd_pkg::t_hpd_dec             o_dec
);
    import hpd_pkg::*;

    always_comb begin
        o_dec.op    = OP_HOLD;
        o_dec.inten = '0;
        o_dec.idx   = '0;
        if (i_ham_mode == MODE_HAM6) begin
            // replicate the nibble into both halves
            o_dec.inten = {2{i_code[3:0]}};
            o_dec.idx   = {2'b00, i_code[3:0]};
            unique case (i_code[7:4])
                CTL6_LOAD:  o_dec.op = OP_LOAD;
                CTL6_BLUE:  o_dec.op = OP_BLUE;
                CTL6_RED:   o_dec.op = OP_RED;
                CTL6_GREEN: o_dec.op = OP_GREEN;
                default:    o_dec.op = OP_HOLD;
            endcase
        end else begin
            // widen six bits by repeating the top two below
            o_dec.inten = {i_code[5:0], i_code[5:4]};
            o_dec.idx   = i_code[5:0];
            unique case (i_code[7:6])
                CTL8_LOAD:  o_dec.op = OP_LOAD;
                CTL8_BLUE:  o_dec.op = OP_BLUE;
                CTL8_RED:   o_dec.op = OP_RED;
                CTL8_GREEN: o_dec.op = OP_GREEN;
            endcase
        end
    end

endmodule

// ----- rtl/ham_pixel_decoder_top.sv -----
// Hold-and-modify pixel decoder, HAM6 and HAM8, 24-bit RGB out.
// An accepted pixel is registered in stage 1 with its palette read, then in the
// output register that drives o_valid. One item per clock while i_ready does not
// stall the output; the palette is one synchronous RAM with a single read port.
// Reset (synchronous, active low) clears the held color, the mode and valid flags;
// the palette is not cleared and must be written before an entry is read.
`include "ham_pixel_decoder_top_assert.svh"

module ham_pixel_decoder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_ham_mode,

    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_req_type,
    input  logic [hpd_pkg::CODE_W-1:0]       i_pixel_code,
    input  logic                             i_first_pixel,
    input  logic [hpd_pkg::PAL_IDX_W-1:0]    i_pal_index,
    input  logic [hpd_pkg::CHAN_W-1:0]       i_pal_red,
    input  logic [hpd_pkg::CHAN_W-1:0]       i_pal_green,
    input  logic [hpd_pkg::CHAN_W-1:0]       i_pal_blue,

    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [hpd_pkg::CHAN_W-1:0]       o_out_red,
    output logic [hpd_pkg::CHAN_W-1:0]       o_out_green,
    output logic [hpd_pkg::CHAN_W-1:0]       o_out_blue
);
    import hpd_pkg::*;

    logic                     r_ham_mode;

    logic [COLOR_W-1:0]       r_pal [PAL_ENTRIES];
    logic [COLOR_W-1:0]       r_rd_data;

    logic                     r_s1_vld;
    t_ham_op                  r_s1_op;
    logic                     r_s1_first;
    logic [CHAN_W-1:0]        r_s1_inten;
    logic                     r_s1_oob;

    logic [COLOR_W-1:0]       r_held;
    logic                     r_out_vld;
    logic [CHAN_W-1:0]        r_out_red;
    logic [CHAN_W-1:0]        r_out_green;
    logic [CHAN_W-1:0]        r_out_blue;

    t_hpd_dec                 dec;
    logic                     in_acc;
    logic                     s1_adv;
    logic                     s1_fire;
    logic                     rd_en;
    logic                     wr_en;
    logic [PAL_IDX_W-1:0]     rd_idx;
    logic                     rd_oob;
    logic [COLOR_W-1:0]       pal_q;
    logic [COLOR_W-1:0]       base;
    logic [COLOR_W-1:0]       n_color;

    hpd_code_dec u_dec (
        .i_ham_mode (r_ham_mode),
        .i_code     (i_pixel_code),
        .o_dec      (dec)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ham_mode <= MODE_HAM6;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ham_mode <= i_cfg_ham_mode;
        end
    end

    // stage 1 moves on when the output register is free or being drained
    assign s1_adv  = !r_out_vld || i_ready;
    assign s1_fire = r_s1_vld && s1_adv;
    assign o_ready = !r_s1_vld || s1_adv;
    assign in_acc  = i_valid && o_ready;

    // one palette read per pixel: the loaded entry, else entry 0 as base for a first pixel
    assign rd_idx = (dec.op == OP_LOAD) ? dec.idx : '0;
    assign rd_oob = {1'b0, rd_idx} >= PAL_LIM;
    assign rd_en  = in_acc && (i_req_type == REQ_PIXEL);
    assign wr_en  = in_acc && (i_req_type == REQ_PALETTE) && ({1'b0, i_pal_index} < PAL_LIM);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pal[i_pal_index[PAL_AW-1:0]] <= {i_pal_red, i_pal_green, i_pal_blue};
        end
        if (rd_en) begin
            r_rd_data <= r_pal[rd_idx[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_op    <= dec.op;
            r_s1_first <= i_first_pixel;
            r_s1_inten <= dec.inten;
            r_s1_oob   <= rd_oob;
        end
    end

    assign pal_q = r_s1_oob ? '0 : r_rd_data;
    assign base  = (r_s1_op == OP_LOAD || r_s1_first) ? pal_q : r_held;

    always_comb begin
        unique case (r_s1_op)
            OP_LOAD:  n_color = pal_q;
            OP_BLUE:  n_color = {base[COLOR_W-1:CHAN_W], r_s1_inten};
            OP_RED:   n_color = {r_s1_inten, base[2*CHAN_W-1:0]};
            OP_GREEN: n_color = {base[COLOR_W-1:2*CHAN_W], r_s1_inten, base[CHAN_W-1:0]};
            default:  n_color = base;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_held    <= n_color;
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_red   <= n_color[COLOR_W-1:2*CHAN_W];
            r_out_green <= n_color[2*CHAN_W-1:CHAN_W];
            r_out_blue  <= n_color[CHAN_W-1:0];
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;

    `HPD_ASSERT_NEXT(a_write_no_result, in_acc && (i_req_type == REQ_PALETTE), !r_s1_vld, "palette write produced a stage-1 item")
    `HPD_ASSERT_NEXT(a_pixel_enters_s1, rd_en, r_s1_vld, "accepted pixel missing from stage 1")
    `HPD_ASSERT_NEXT(a_rd_data_holds, r_s1_vld && !s1_adv, $stable(r_rd_data), "palette read data changed while stalled")
    `HPD_ASSERT_NEXT(a_held_stable, !s1_fire, $stable(r_held), "held color changed without a decoded pixel")
    `HPD_ASSERT_NOW(a_no_overwrite, r_out_vld && !i_ready, !s1_fire, "result overwritten while waiting")

endmodule
